### rtl/core/dsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_pkg
// Character codes, limits, widths and the snapshot type shared by the
// date string parser modules.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int CHAR_W  = 8;
  localparam int YEAR_W  = 31;
  localparam int MAG_W   = 20;
  localparam int SCALE_W = 30;
  localparam int GROUP_W = 14;
  localparam int STAR_W  = 3;
  localparam int PREC_W  = 3;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [MAG_W-1:0]   YEAR_MAX  = 20'd999999;
  localparam logic [GROUP_W-1:0] GROUP_MAX = 14'd9999;
  localparam logic [STAR_W-1:0]  STAR_MAX  = 3'd4;

  localparam logic [STAR_W-1:0] STARS_NONE   = 3'd0;
  localparam logic [STAR_W-1:0] STARS_DECADE = 3'd1;
  localparam logic [STAR_W-1:0] STARS_CENT   = 3'd2;
  localparam logic [STAR_W-1:0] STARS_MILL   = 3'd3;

  localparam logic [PREC_W-1:0] PREC_NONE   = 3'd0;
  localparam logic [PREC_W-1:0] PREC_MILL   = 3'd1;
  localparam logic [PREC_W-1:0] PREC_CENT   = 3'd2;
  localparam logic [PREC_W-1:0] PREC_DECADE = 3'd3;
  localparam logic [PREC_W-1:0] PREC_YEAR   = 3'd4;
  localparam logic [PREC_W-1:0] PREC_MONTH  = 3'd5;
  localparam logic [PREC_W-1:0] PREC_DAY    = 3'd6;

  typedef struct packed {
    logic               is_bc;
    logic [MAG_W-1:0]   year_mag;
    logic [STAR_W-1:0]  stars;
    logic [GROUP_W-1:0] month;
    logic [GROUP_W-1:0] day;
    logic               sat;
  } snap_t;

endpackage

### rtl/core/dsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_if
// Valid/ready channels of the date string parser: character in, date out.
// ----------------------------------------------------------------------------
interface dsp_in_if import dsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dsp_out_if import dsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [YEAR_W-1:0]  year_value;
  logic        [GROUP_W-1:0] month_value;
  logic        [GROUP_W-1:0] day_value;
  logic        [PREC_W-1:0]  precision_code;
  logic                      overflow_flag;

  modport source (output valid, output year_value, output month_value,
                  output day_value, output precision_code, output overflow_flag,
                  input ready);
  modport sink   (input valid, input year_value, input month_value,
                  input day_value, input precision_code, input overflow_flag,
                  output ready);
endinterface

### rtl/core/dsp_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_scan
// Parse state machine: folds one character per cycle (a last character stalls while
// the snapshot is still held) into sign, year, star, month and day accumulators, snapshotting on the last character.
// ----------------------------------------------------------------------------
module dsp_scan import dsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_vld,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              last_char,
  input  logic              snap_take,
  output logic              adv,
  output logic              snap_vld_r,
  output snap_t             snap_r
);

  typedef enum logic [2:0] {
    PH_START, PH_YEAR, PH_STARS, PH_MONTH, PH_DAY, PH_DONE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               bc_r, bc_nxt;
  logic [MAG_W-1:0]   year_r, year_nxt;
  logic [STAR_W-1:0]  stars_r, stars_nxt;
  logic [GROUP_W-1:0] month_r, month_nxt;
  logic [GROUP_W-1:0] day_r, day_nxt;
  logic               sat_r, sat_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic              year_mode;
  logic [MAG_W:0]    year_acc;
  logic [MAG_W:0]    month_acc;
  logic [MAG_W:0]    day_acc;

  function automatic logic [MAG_W:0] accum(input logic [MAG_W-1:0] acc,
                                           input logic [3:0]       d,
                                           input logic [MAG_W-1:0] lim);
    logic [MAG_W+3:0] n;
    n = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{MAG_W{1'b0}}, d};
    if (n > {4'b0, lim}) begin
      return {1'b1, lim};
    end
    return {1'b0, n[MAG_W-1:0]};
  endfunction

  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit     = is_digit ? 4'(char_code - CH_ZERO) : 4'd0;
  assign year_acc  = accum(year_r, digit, YEAR_MAX);
  assign month_acc = accum({{(MAG_W-GROUP_W){1'b0}}, month_r}, digit,
                           {{(MAG_W-GROUP_W){1'b0}}, GROUP_MAX});
  assign day_acc   = accum({{(MAG_W-GROUP_W){1'b0}}, day_r}, digit,
                           {{(MAG_W-GROUP_W){1'b0}}, GROUP_MAX});
  assign year_mode = (phase_r == PH_YEAR) ||
                     ((phase_r == PH_START) && (char_code != CH_PLUS) &&
                      (char_code != CH_MINUS));

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    year_nxt  = year_r;
    stars_nxt = stars_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    sat_nxt   = sat_r;
    if (year_mode) begin
      if (is_digit) begin
        year_nxt  = year_acc[MAG_W-1:0];
        sat_nxt   = sat_r | year_acc[MAG_W];
        phase_nxt = PH_YEAR;
      end else if (char_code == CH_STAR) begin
        stars_nxt = STARS_DECADE;
        phase_nxt = PH_STARS;
      end else if (char_code == CH_MINUS) begin
        phase_nxt = PH_MONTH;
      end else begin
        phase_nxt = PH_DONE;
      end
    end else begin
      case (phase_r)
        PH_START: begin
          bc_nxt    = (char_code == CH_MINUS);
          phase_nxt = PH_YEAR;
        end
        PH_STARS: begin
          if (char_code == CH_STAR) begin
            if (stars_r < STAR_MAX) begin
              stars_nxt = stars_r + 3'd1;
            end
          end else if (char_code == CH_MINUS) begin
            phase_nxt = PH_MONTH;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_MONTH: begin
          if (is_digit) begin
            month_nxt = month_acc[GROUP_W-1:0];
            sat_nxt   = sat_r | month_acc[MAG_W];
          end else if (char_code == CH_MINUS) begin
            phase_nxt = PH_DAY;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_DAY: begin
          if (is_digit) begin
            day_nxt = day_acc[GROUP_W-1:0];
            sat_nxt = sat_r | day_acc[MAG_W];
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  assign adv = item_vld && (!last_char || !snap_vld_r || snap_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      bc_r       <= 1'b0;
      year_r     <= '0;
      stars_r    <= STARS_NONE;
      month_r    <= '0;
      day_r      <= '0;
      sat_r      <= 1'b0;
      snap_vld_r <= 1'b0;
    end else begin
      if (adv && last_char) begin
        phase_r <= PH_START;
        bc_r    <= 1'b0;
        year_r  <= '0;
        stars_r <= STARS_NONE;
        month_r <= '0;
        day_r   <= '0;
        sat_r   <= 1'b0;
      end else if (adv) begin
        phase_r <= phase_nxt;
        bc_r    <= bc_nxt;
        year_r  <= year_nxt;
        stars_r <= stars_nxt;
        month_r <= month_nxt;
        day_r   <= day_nxt;
        sat_r   <= sat_nxt;
      end
      if (adv && last_char) begin
        snap_vld_r <= 1'b1;
      end else if (snap_take) begin
        snap_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_char) begin
      snap_r <= '{is_bc: bc_nxt, year_mag: year_nxt, stars: stars_nxt,
                  month: month_nxt, day: day_nxt, sat: sat_nxt};
    end
  end

endmodule

### rtl/core/dsp_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsp_format
// Result stage: scales the year by the star count (four stars leave it unscaled), applies the sign, derives
// the precision and holds the date in the output register.
// ----------------------------------------------------------------------------
module dsp_format import dsp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          snap_vld,
  input  snap_t         snap,
  output logic          snap_take,
  dsp_out_if.source     out_item
);

  logic                      out_vld_r;
  logic signed [YEAR_W-1:0]  year_r;
  logic        [GROUP_W-1:0] month_r;
  logic        [GROUP_W-1:0] day_r;
  logic        [PREC_W-1:0]  prec_r;
  logic                      ovf_r;

  logic [SCALE_W-1:0] mag;
  logic [SCALE_W-1:0] scaled;
  logic [PREC_W-1:0]  prec_nxt;
  logic [YEAR_W-1:0]  year_nxt;

  assign mag = {{(SCALE_W-MAG_W){1'b0}}, snap.year_mag};

  always_comb begin
    case (snap.stars)
      STARS_NONE: begin
        scaled   = mag;
        prec_nxt = PREC_YEAR;
      end
      STARS_DECADE: begin
        scaled   = (mag << 3) + (mag << 1);
        prec_nxt = PREC_DECADE;
      end
      STARS_CENT: begin
        scaled   = (mag << 6) + (mag << 5) + (mag << 2) + 30'd1;
        prec_nxt = PREC_CENT;
      end
      STARS_MILL: begin
        scaled   = (mag << 10) - (mag << 4) - (mag << 3) + 30'd1;
        prec_nxt = PREC_MILL;
      end
      default: begin
        scaled   = mag;
        prec_nxt = PREC_NONE;
      end
    endcase
    if (snap.month != '0) begin
      prec_nxt = PREC_MONTH;
    end
    if (snap.day != '0) begin
      prec_nxt = PREC_DAY;
    end
    year_nxt = snap.is_bc ? (YEAR_W'(0) - {1'b0, scaled}) : {1'b0, scaled};
  end

  assign snap_take = snap_vld && (!out_vld_r || out_item.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (snap_take) begin
      out_vld_r <= 1'b1;
    end else if (out_item.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      year_r  <= signed'(year_nxt);
      month_r <= snap.month;
      day_r   <= snap.day;
      prec_r  <= prec_nxt;
      ovf_r   <= snap.sat;
    end
  end

  assign out_item.valid          = out_vld_r;
  assign out_item.year_value     = year_r;
  assign out_item.month_value    = month_r;
  assign out_item.day_value      = day_r;
  assign out_item.precision_code = prec_r;
  assign out_item.overflow_flag  = ovf_r;

endmodule

### rtl/core/date_string_parser.sv
`timescale 1ns / 1ps
// A date passes the input register and the snapshot register into the output register.
// Throughput: one character per cycle; a last character stalls while the snapshot is held.
// Each stage has its own valid bit: a date waiting at the output stalls only a last character.
// Reset: synchronous, active low; clears the valid bits and the parse state to "expect sign".
// ----------------------------------------------------------------------------
// date_string_parser
// Streaming date string parser: input register, parse state machine and
// result register.
// ----------------------------------------------------------------------------
module date_string_parser import dsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dsp_in_if.sink    in_item,
  dsp_out_if.source out_item
);

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;
  logic              scan_adv;
  logic              snap_vld;
  logic              snap_take;
  snap_t             snap;

  assign in_item.ready = !in_vld_r || scan_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_item.ready) begin
      in_vld_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      in_char_r <= in_item.char_code;
      in_last_r <= in_item.last_char;
    end
  end

  dsp_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (in_vld_r),
    .char_code  (in_char_r),
    .last_char  (in_last_r),
    .snap_take  (snap_take),
    .adv        (scan_adv),
    .snap_vld_r (snap_vld),
    .snap_r     (snap)
  );

  dsp_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_vld  (snap_vld),
    .snap      (snap),
    .snap_take (snap_take),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> in_vld_r)
    else $error("input stalled with empty input register");

  a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
    snap_vld && !snap_take |=> snap_vld)
    else $error("snapshot dropped before the result stage took it");

  a_plain_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_adv && !in_last_r && !snap_vld |=> !snap_vld)
    else $error("snapshot raised by a character that is not last");

  a_month_raises_prec: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid && (out_item.month_value != '0) |->
      (out_item.precision_code == PREC_MONTH) || (out_item.precision_code == PREC_DAY))
    else $error("month present without month or day precision");
`endif

endmodule
